FILE: rtl/rvc_cfd_pkg.sv
package rvc_cfd_pkg;

   localparam int unsigned InstrWidth = 16;
   localparam int unsigned OpWidth    = 4;
   localparam int unsigned F3Width    = 3;
   localparam int unsigned RegWidth   = 5;
   localparam int unsigned ImmWidth   = 18;
   localparam int unsigned KeyWidth   = 5;

   typedef enum logic [1:0] {
      STATUS_DECODED    = 2'd0,
      STATUS_RECOGNIZED = 2'd1,
      STATUS_UNKNOWN    = 2'd2
   } status_type;

   typedef logic [KeyWidth-1:0] key_type;

   // {funct3, quadrant}
   localparam key_type KEY_ADDI4SPN = 5'h00;
   localparam key_type KEY_NOP_ADDI = 5'h01;
   localparam key_type KEY_SLLI     = 5'h02;
   localparam key_type KEY_Q0_FLD   = 5'h04;
   localparam key_type KEY_JAL      = 5'h05;
   localparam key_type KEY_Q2_FLDSP = 5'h06;
   localparam key_type KEY_LW       = 5'h08;
   localparam key_type KEY_LI       = 5'h09;
   localparam key_type KEY_LWSP     = 5'h0a;
   localparam key_type KEY_Q0_FLW   = 5'h0c;
   localparam key_type KEY_LUI      = 5'h0d;
   localparam key_type KEY_Q2_FLWSP = 5'h0e;
   localparam key_type KEY_ALU      = 5'h11;
   localparam key_type KEY_CR       = 5'h12;
   localparam key_type KEY_Q0_FSD   = 5'h14;
   localparam key_type KEY_J        = 5'h15;
   localparam key_type KEY_Q2_FSDSP = 5'h16;
   localparam key_type KEY_SW       = 5'h18;
   localparam key_type KEY_BEQZ     = 5'h19;
   localparam key_type KEY_SWSP     = 5'h1a;
   localparam key_type KEY_Q0_FSW   = 5'h1c;
   localparam key_type KEY_BNEZ     = 5'h1d;
   localparam key_type KEY_Q2_FSWSP = 5'h1e;

   localparam logic [RegWidth-1:0] REG_ZERO = 5'd0;
   localparam logic [RegWidth-1:0] REG_SP   = 5'd2;

   typedef struct packed {
      logic [OpWidth-1:0]  major_op;
      logic [F3Width-1:0]  func_sel;
      logic [RegWidth-1:0] dest_reg;
      logic [RegWidth-1:0] src1_reg;
      logic [RegWidth-1:0] src2_reg;
      logic [ImmWidth-1:0] immediate;
      status_type          status;
   } result_type;

endpackage

FILE: rtl/rvc_cfd_if.sv
interface rvc_cfd_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [rvc_cfd_pkg::InstrWidth-1:0]   instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvc_cfd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rvc_cfd_pkg::OpWidth-1:0]    major_op;
   logic [rvc_cfd_pkg::F3Width-1:0]    func_sel;
   logic [rvc_cfd_pkg::RegWidth-1:0]   dest_reg;
   logic [rvc_cfd_pkg::RegWidth-1:0]   src1_reg;
   logic [rvc_cfd_pkg::RegWidth-1:0]   src2_reg;
   logic [rvc_cfd_pkg::ImmWidth-1:0]   immediate;
   rvc_cfd_pkg::status_type            status;

   modport source (output valid, output major_op, output func_sel, output dest_reg,
                   output src1_reg, output src2_reg, output immediate, output status,
                   input ready);
   modport sink   (input valid, input major_op, input func_sel, input dest_reg,
                   input src1_reg, input src2_reg, input immediate, input status,
                   output ready);
endinterface

FILE: rtl/rvc_compressed_field_decoder_top.sv
// Channel   Role    Transaction payload
// req_chan  sink    instr_word (16-bit compressed instruction)
// rsp_chan  source  major_op, func_sel, dest_reg, src1_reg, src2_reg, immediate, status
//
// One instruction per cycle sustained while rsp_chan.ready holds; the path runs from the
// input register to the result register, with the field decode between them.
// Synchronous active-high reset empties both stages; payload registers are not reset.
// A stalled result holds in the result register while the input register keeps
// one more instruction; req_chan.ready drops only when both stages are full.
module rvc_compressed_field_decoder_top (
   input logic            clock,
   input logic            reset,
   rvc_cfd_req_if.sink    req_chan,
   rvc_cfd_rsp_if.source  rsp_chan
);

   logic                                 in_valid_ff, in_valid_in;
   logic [rvc_cfd_pkg::InstrWidth-1:0]   in_word_ff;
   logic                                 out_valid_ff, out_valid_in;
   rvc_cfd_pkg::result_type              out_ff, out_in;
   logic                                 out_ready;
   logic                                 in_ready;

   logic [rvc_cfd_pkg::InstrWidth-1:0]   w;
   rvc_cfd_pkg::key_type                 key;
   logic [rvc_cfd_pkg::RegWidth-1:0]     wide;
   logic [rvc_cfd_pkg::RegWidth-1:0]     rd, r1, r2;
   logic [rvc_cfd_pkg::ImmWidth-1:0]     imm;
   logic [rvc_cfd_pkg::OpWidth-1:0]      op;
   rvc_cfd_pkg::status_type              st;

   assign out_ready      = !out_valid_ff || rsp_chan.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_chan.ready = in_ready;

   assign in_valid_in  = req_chan.valid || (in_valid_ff && !out_ready);
   assign out_valid_in = in_valid_ff || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= in_valid_in;
         end
         if (out_ready) begin
            out_valid_ff <= out_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && req_chan.valid) begin
         in_word_ff <= req_chan.instr_word;
      end
      if (out_ready && in_valid_ff) begin
         out_ff <= out_in;
      end
   end

   assign w    = in_word_ff;
   assign key  = {w[15:13], w[1:0]};
   assign wide = w[11:7];

   always_comb begin
      op  = {2'b00, w[1:0]};
      rd  = '0;
      r1  = '0;
      r2  = '0;
      imm = '0;
      st  = rvc_cfd_pkg::STATUS_DECODED;
      unique case (key) inside
         rvc_cfd_pkg::KEY_CR: begin
            op = w[3:0];
            r2 = w[6:2];
            r1 = wide;
            rd = wide;
         end
         rvc_cfd_pkg::KEY_LWSP: begin
            rd  = wide;
            r1  = wide;
            imm = {10'd0, w[3:2], w[12], w[6:4], 2'b00};
         end
         rvc_cfd_pkg::KEY_LI, rvc_cfd_pkg::KEY_SLLI: begin
            rd  = wide;
            r1  = wide;
            imm = {12'd0, w[12], w[6:2]};
         end
         rvc_cfd_pkg::KEY_LUI: begin
            rd = wide;
            r1 = wide;
            if (wide == rvc_cfd_pkg::REG_SP) begin
               imm = {8'd0, w[12], w[4:3], w[5], w[2], w[6], 4'd0};
            end else if (wide != rvc_cfd_pkg::REG_ZERO) begin
               imm = {w[12], w[6:2], 12'd0};
            end
         end
         rvc_cfd_pkg::KEY_NOP_ADDI: begin
            rd = wide;
            r1 = wide;
            if (wide != rvc_cfd_pkg::REG_ZERO) begin
               imm = {12'd0, w[12], w[6:2]};
            end
         end
         rvc_cfd_pkg::KEY_SWSP: begin
            r2  = w[6:2];
            imm = {10'd0, w[8:7], w[12:9], 2'b00};
         end
         rvc_cfd_pkg::KEY_ADDI4SPN: begin
            if (w[12:5] == 8'd0) begin
               st = rvc_cfd_pkg::STATUS_RECOGNIZED;
            end else begin
               rd  = {2'b00, w[4:2]};
               imm = {8'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
            end
         end
         rvc_cfd_pkg::KEY_LW, rvc_cfd_pkg::KEY_SW: begin
            if (key == rvc_cfd_pkg::KEY_LW) begin
               rd = {2'b00, w[4:2]};
            end else begin
               r2 = {2'b00, w[4:2]};
            end
            r1  = {2'b00, w[9:7]};
            imm = {11'd0, w[5], w[12:10], w[6], 2'b00};
         end
         rvc_cfd_pkg::KEY_BEQZ, rvc_cfd_pkg::KEY_BNEZ: begin
            r1  = {2'b00, w[9:7]};
            imm = {9'd0, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
         end
         rvc_cfd_pkg::KEY_J, rvc_cfd_pkg::KEY_JAL: begin
            imm = {6'd0, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
         end
         rvc_cfd_pkg::KEY_Q0_FLD, rvc_cfd_pkg::KEY_Q0_FLW, rvc_cfd_pkg::KEY_Q0_FSD,
         rvc_cfd_pkg::KEY_Q0_FSW, rvc_cfd_pkg::KEY_ALU, rvc_cfd_pkg::KEY_Q2_FLDSP,
         rvc_cfd_pkg::KEY_Q2_FLWSP, rvc_cfd_pkg::KEY_Q2_FSDSP,
         rvc_cfd_pkg::KEY_Q2_FSWSP: begin
            st = rvc_cfd_pkg::STATUS_RECOGNIZED;
         end
         default: begin
            st = rvc_cfd_pkg::STATUS_UNKNOWN;
         end
      endcase
   end

   always_comb begin
      out_in.major_op  = op;
      out_in.func_sel  = w[15:13];
      out_in.status    = st;
      if (st == rvc_cfd_pkg::STATUS_DECODED) begin
         out_in.dest_reg  = rd;
         out_in.src1_reg  = r1;
         out_in.src2_reg  = r2;
         out_in.immediate = imm;
      end else begin
         out_in.dest_reg  = '0;
         out_in.src1_reg  = '0;
         out_in.src2_reg  = '0;
         out_in.immediate = '0;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.major_op  = out_ff.major_op;
   assign rsp_chan.func_sel  = out_ff.func_sel;
   assign rsp_chan.dest_reg  = out_ff.dest_reg;
   assign rsp_chan.src1_reg  = out_ff.src1_reg;
   assign rsp_chan.src2_reg  = out_ff.src2_reg;
   assign rsp_chan.immediate = out_ff.immediate;
   assign rsp_chan.status    = out_ff.status;

endmodule

FILE: verif/rvc_cfd_checker.sv
`timescale 1ns / 1ps

module rvc_cfd_checker (
   input  logic   clock,
   input  logic   reset,
   rvc_cfd_req_if req_chan,
   rvc_cfd_rsp_if rsp_chan,
   output int     errors,
   output int     pending
);

   typedef logic [rvc_cfd_pkg::InstrWidth-1:0] instr_type;
   typedef logic [rvc_cfd_pkg::ImmWidth-1:0]   imm_type;

   typedef struct {
      instr_type               instr;
      rvc_cfd_pkg::result_type fields;
   } decode_entry_type;

   decode_entry_type decode_q[$];

   function automatic rvc_cfd_pkg::result_type decode_compressed(input instr_type w);
      rvc_cfd_pkg::result_type          r;
      rvc_cfd_pkg::key_type             key;
      logic [rvc_cfd_pkg::RegWidth-1:0] wide;
      r          = '0;
      r.major_op = {2'b00, w[1:0]};
      r.func_sel = w[15:13];
      r.status   = rvc_cfd_pkg::STATUS_DECODED;
      key        = {w[15:13], w[1:0]};
      wide       = w[11:7];
      case (key)
         rvc_cfd_pkg::KEY_CR: begin
            r.major_op = w[3:0];
            r.src2_reg = w[6:2];
            r.src1_reg = wide;
            r.dest_reg = wide;
         end
         rvc_cfd_pkg::KEY_LWSP: begin
            r.dest_reg  = wide;
            r.src1_reg  = wide;
            r.immediate = imm_type'({w[3:2], w[12], w[6:4], 2'b00});
         end
         rvc_cfd_pkg::KEY_LI, rvc_cfd_pkg::KEY_SLLI: begin
            r.dest_reg  = wide;
            r.src1_reg  = wide;
            r.immediate = imm_type'({w[12], w[6:2]});
         end
         rvc_cfd_pkg::KEY_LUI: begin
            r.dest_reg = wide;
            r.src1_reg = wide;
            if (wide == rvc_cfd_pkg::REG_SP) begin
               r.immediate = imm_type'({w[12], w[4:3], w[5], w[2], w[6], 4'b0000});
            end else if (wide != rvc_cfd_pkg::REG_ZERO) begin
               r.immediate = imm_type'({w[12], w[6:2], 12'h000});
            end
         end
         rvc_cfd_pkg::KEY_NOP_ADDI: begin
            r.dest_reg = wide;
            r.src1_reg = wide;
            if (wide != rvc_cfd_pkg::REG_ZERO) begin
               r.immediate = imm_type'({w[12], w[6:2]});
            end
         end
         rvc_cfd_pkg::KEY_SWSP: begin
            r.src2_reg  = w[6:2];
            r.immediate = imm_type'({w[8:7], w[12:9], 2'b00});
         end
         rvc_cfd_pkg::KEY_ADDI4SPN: begin
            if (w[12:5] == 8'h00) begin
               r.status = rvc_cfd_pkg::STATUS_RECOGNIZED;
            end else begin
               r.dest_reg  = {2'b00, w[4:2]};
               r.immediate = imm_type'({w[10:7], w[12:11], w[5], w[6], 2'b00});
            end
         end
         rvc_cfd_pkg::KEY_LW, rvc_cfd_pkg::KEY_SW: begin
            if (key == rvc_cfd_pkg::KEY_LW) begin
               r.dest_reg = {2'b00, w[4:2]};
            end else begin
               r.src2_reg = {2'b00, w[4:2]};
            end
            r.src1_reg  = {2'b00, w[9:7]};
            r.immediate = imm_type'({w[5], w[12:10], w[6], 2'b00});
         end
         rvc_cfd_pkg::KEY_BEQZ, rvc_cfd_pkg::KEY_BNEZ: begin
            r.src1_reg  = {2'b00, w[9:7]};
            r.immediate = imm_type'({w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0});
         end
         rvc_cfd_pkg::KEY_J, rvc_cfd_pkg::KEY_JAL: begin
            r.immediate = imm_type'({w[12], w[8], w[10:9], w[6], w[7], w[2], w[11],
                                     w[5:3], 1'b0});
         end
         rvc_cfd_pkg::KEY_Q0_FLD, rvc_cfd_pkg::KEY_Q0_FLW, rvc_cfd_pkg::KEY_Q0_FSD,
         rvc_cfd_pkg::KEY_Q0_FSW, rvc_cfd_pkg::KEY_ALU, rvc_cfd_pkg::KEY_Q2_FLDSP,
         rvc_cfd_pkg::KEY_Q2_FLWSP, rvc_cfd_pkg::KEY_Q2_FSDSP,
         rvc_cfd_pkg::KEY_Q2_FSWSP: begin
            r.status = rvc_cfd_pkg::STATUS_RECOGNIZED;
         end
         default: begin
            r.status = rvc_cfd_pkg::STATUS_UNKNOWN;
         end
      endcase
      if (r.status != rvc_cfd_pkg::STATUS_DECODED) begin
         r.dest_reg  = '0;
         r.src1_reg  = '0;
         r.src2_reg  = '0;
         r.immediate = '0;
      end
      return r;
   endfunction

   task automatic report(input string what, input instr_type instr,
                         input int got, input int want);
      $display("checker: %s mismatch at %0t, instr %h, got %0h want %0h",
               what, $realtime, instr, got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      decode_entry_type e;
      if (reset) begin
         errors = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (decode_q.size() == 0) begin
               report("unexpected transaction", '0, int'(rsp_chan.major_op), 0);
            end else begin
               e = decode_q.pop_front();
               if (rsp_chan.major_op !== e.fields.major_op)
                  report("major_op", e.instr, int'(rsp_chan.major_op),
                         int'(e.fields.major_op));
               if (rsp_chan.func_sel !== e.fields.func_sel)
                  report("func_sel", e.instr, int'(rsp_chan.func_sel),
                         int'(e.fields.func_sel));
               if (rsp_chan.dest_reg !== e.fields.dest_reg)
                  report("dest_reg", e.instr, int'(rsp_chan.dest_reg),
                         int'(e.fields.dest_reg));
               if (rsp_chan.src1_reg !== e.fields.src1_reg)
                  report("src1_reg", e.instr, int'(rsp_chan.src1_reg),
                         int'(e.fields.src1_reg));
               if (rsp_chan.src2_reg !== e.fields.src2_reg)
                  report("src2_reg", e.instr, int'(rsp_chan.src2_reg),
                         int'(e.fields.src2_reg));
               if (rsp_chan.immediate !== e.fields.immediate)
                  report("immediate", e.instr, int'(rsp_chan.immediate),
                         int'(e.fields.immediate));
               if (rsp_chan.status !== e.fields.status)
                  report("status", e.instr, int'(rsp_chan.status), int'(e.fields.status));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            e.instr  = req_chan.instr_word;
            e.fields = decode_compressed(req_chan.instr_word);
            decode_q.push_back(e);
         end
      end
      pending <= decode_q.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;

   typedef logic [rvc_cfd_pkg::InstrWidth-1:0] instr_type;

   localparam int NumRandom     = 450;
   localparam int PauseAt       = 300;
   localparam int CalmFirst     = 150;
   localparam int CalmLast      = 250;
   localparam int StallLimit    = 1000;
   localparam int DrainCycles   = 8;

   localparam instr_type DIRECTED [25] = '{
      16'h0000, 16'h1ffc, 16'h0001, 16'h1ffd, 16'h3ffd, 16'h5ffd, 16'h707d,
      16'h717d, 16'h7ffd, 16'h9ffd, 16'hbffd, 16'hdffd, 16'hfffd, 16'h5ffc,
      16'hdffc, 16'h9ffc, 16'hfffc, 16'h1ffe, 16'h5ffe, 16'h7ffe, 16'h9ffe,
      16'h8002, 16'hdffe, 16'hfffe, 16'hffff
   };

   logic clock = 1'b0;
   logic reset;
   logic calm  = 1'b0;
   int   errors;
   int   pending;
   int   stall_count = 0;

   rvc_cfd_req_if req_if ();
   rvc_cfd_rsp_if rsp_if ();

   rvc_compressed_field_decoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   rvc_cfd_checker checker_inst (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .errors   (errors),
      .pending  (pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_if.ready <= calm || ($urandom_range(0, 99) >= 9);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= StallLimit) begin
         $display("tb: errors");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   function automatic instr_type random_instr();
      instr_type w;
      w = instr_type'($urandom);
      if ($urandom_range(0, 99) >= 8) begin
         w[1:0] = 2'($urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0: w[11:7] = rvc_cfd_pkg::REG_ZERO;
            1: w[11:7] = rvc_cfd_pkg::REG_SP;
            2: w[12:5] = '0;
            default: ;
         endcase
      end
      return w;
   endfunction

   task automatic send_instr(input instr_type w);
      while (!calm && $urandom_range(0, 99) < 9) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.instr_word <= w;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.instr_word = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (DIRECTED[i]) send_instr(DIRECTED[i]);
      for (int i = 0; i < NumRandom; i++) begin
         if (i == PauseAt) begin
            req_if.valid <= 1'b0;
            @(negedge clock);
            while (pending != 0) @(negedge clock);
         end
         calm <= (i >= CalmFirst) && (i < CalmLast);
         send_instr(random_instr());
      end
      req_if.valid <= 1'b0;
      calm         <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (errors == 0 && pending == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/rvc_cfd_pkg.sv
rtl/rvc_cfd_if.sv
rtl/rvc_compressed_field_decoder_top.sv
verif/rvc_cfd_checker.sv
verif/tb.sv
